>>> sv/lesq_pkg.sv
`timescale 1ns / 1ps
// Shared widths, reset values, register indexes and pipeline control type
// for the largest empty square search. No dependencies.
package lesq_pkg;

    localparam int CHAR_W       = 8;
    localparam int ROWCNT_W     = 11;
    localparam int SCORE_W      = 11;
    localparam int POS_W        = 10;
    localparam int CFG_IDX_W    = 1;
    localparam int OUT_DATA_W   = 32;
    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;

    localparam logic [CHAR_W-1:0]   OBSTACLE_RESET  = 8'd111;
    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBSTACLE_CHAR = 1'b0,
        CFG_ROW_COUNT     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic border;
        logic col_end;
        logic last;
    } cell_ctl_t;

endpackage

>>> sv/lesq_score_core.sv
`timescale 1ns / 1ps
// Column score store and per-cell scoring: read, score, write back, with
// forwarding for back-to-back access to one entry. Depends on lesq_pkg.
module lesq_score_core #(
    parameter int MAX_ROWS = lesq_pkg::DEF_MAX_ROWS,
    parameter int ROW_W    = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lesq_pkg::CHAR_W-1:0]   obstacle_char,
    input  lesq_pkg::cell_ctl_t           rd_ctl,
    input  logic [ROW_W-1:0]              rd_addr,
    input  logic [lesq_pkg::CHAR_W-1:0]   rd_char,
    output lesq_pkg::cell_ctl_t           s1_ctl,
    output lesq_pkg::cell_ctl_t           s2_ctl,
    output logic [lesq_pkg::SCORE_W-1:0]  s2_score,
    output logic [ROW_W-1:0]              s2_addr
);
    import lesq_pkg::*;

    logic [SCORE_W-1:0] mem [MAX_ROWS];
    logic [SCORE_W-1:0] mem_q_reg;

    cell_ctl_t          s1_ctl_reg;
    logic [ROW_W-1:0]   s1_addr_reg;
    logic [CHAR_W-1:0]  s1_char_reg;
    logic               fwd_reg;
    logic [SCORE_W-1:0] fwd_score_reg;
    logic [SCORE_W-1:0] above_reg;
    logic [SCORE_W-1:0] diag_reg;
    cell_ctl_t          s2_ctl_reg;
    logic [SCORE_W-1:0] s2_score_reg;
    logic [ROW_W-1:0]   s2_addr_reg;

    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] least;
    logic [SCORE_W-1:0] score;

    always_comb
    begin
        left  = fwd_reg ? fwd_score_reg : mem_q_reg;
        least = above_reg;
        if (diag_reg < least)
        begin
            least = diag_reg;
        end
        if (left < least)
        begin
            least = left;
        end
        if (s1_char_reg == obstacle_char)
        begin
            score = '0;
        end
        else if (s1_ctl_reg.border)
        begin
            score = SCORE_W'(1);
        end
        else
        begin
            score = least + SCORE_W'(1);
        end
    end

    // read and write back the column store
    always_ff @(posedge clk)
    begin
        if (rd_ctl.valid)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        if (s1_ctl_reg.valid)
        begin
            mem[s1_addr_reg] <= score;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg   <= rd_addr;
        s1_char_reg   <= rd_char;
        fwd_score_reg <= score;
        s2_score_reg  <= score;
        s2_addr_reg   <= s1_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            fwd_reg    <= 1'b0;
            above_reg  <= '0;
            diag_reg   <= '0;
        end
        else
        begin
            s1_ctl_reg <= rd_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            // forward the score being written when the next read hits its entry
            fwd_reg    <= rd_ctl.valid && s1_ctl_reg.valid && (rd_addr == s1_addr_reg);
            if (s1_ctl_reg.valid)
            begin
                if (s1_ctl_reg.col_end || s1_ctl_reg.last)
                begin
                    above_reg <= '0;
                    diag_reg  <= '0;
                end
                else
                begin
                    above_reg <= score;
                    diag_reg  <= left;
                end
            end
        end
    end

    assign s1_ctl   = s1_ctl_reg;
    assign s2_ctl   = s2_ctl_reg;
    assign s2_score = s2_score_reg;
    assign s2_addr  = s2_addr_reg;

endmodule

>>> sv/largest_empty_square_search.sv
`timescale 1ns / 1ps
// Largest empty square search over a column-major character map.
// Throughput: one cell per cycle unless a last cell waits, set by the single
// read-modify-write of the column score store. Results pass s1 and s2 into
// an output register. A last cell waits while another result is still in
// flight or held unclaimed at the output. Reset clears all scan state and
// loads the register reset values; the score store needs no clearing pass.
module largest_empty_square_search #(
    parameter int MAX_ROWS = lesq_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lesq_pkg::DEF_MAX_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lesq_pkg::CHAR_W-1:0]       s_axis_tdata,  // [7:0] cell_char
    input  logic                              s_axis_tlast,  // last_cell
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [9:0] top_row, [19:10] left_col, [30:20] square_size, [31] zero
    output logic [lesq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lesq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lesq_pkg::ROWCNT_W-1:0]     cfg_data
);
    import lesq_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = (CNT_W > ROWCNT_W) ? CNT_W : ROWCNT_W;
    localparam int MX_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int SUM_W = ((MX_W > SCORE_W) ? MX_W : SCORE_W) + 1;

    logic [CHAR_W-1:0]   obstacle_reg;
    logic [ROWCNT_W-1:0] row_count_reg;
    logic [ROW_W-1:0]    row_index_reg;
    logic [COL_W-1:0]    col_index_reg;
    logic [COL_W-1:0]    col_s1_reg;
    logic [COL_W-1:0]    col_s2_reg;
    logic [SCORE_W-1:0]  best_size_reg;
    logic [ROW_W-1:0]    best_row_reg;
    logic [COL_W-1:0]    best_col_reg;
    logic                out_valid_reg;
    logic [POS_W-1:0]    top_row_reg;
    logic [POS_W-1:0]    left_col_reg;
    logic [SCORE_W-1:0]  size_reg;

    logic [CMP_W-1:0]    rows_used;
    logic                col_end;
    logic                accept;
    logic                last_in_flight;
    cell_ctl_t           rd_ctl;
    cell_ctl_t           s1_ctl;
    cell_ctl_t           s2_ctl;
    logic [SCORE_W-1:0]  s2_score;
    logic [ROW_W-1:0]    s2_addr;

    logic [SCORE_W-1:0]  best_size_next;
    logic [ROW_W-1:0]    best_row_next;
    logic [COL_W-1:0]    best_col_next;
    logic [SUM_W-1:0]    top_sum;
    logic [SUM_W-1:0]    left_sum;

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_used = CMP_W'(1);
        end
        else if (CMP_W'(row_count_reg) > CMP_W'(MAX_ROWS))
        begin
            rows_used = CMP_W'(MAX_ROWS);
        end
        else
        begin
            rows_used = CMP_W'(row_count_reg);
        end
    end

    assign col_end        = (CMP_W'(row_index_reg) + CMP_W'(1)) >= rows_used;
    assign last_in_flight = (s1_ctl.valid && s1_ctl.last) || (s2_ctl.valid && s2_ctl.last);
    assign s_axis_tready  = !s_axis_tlast
                            || (!last_in_flight && (!out_valid_reg || m_axis_tready));
    assign accept         = s_axis_tvalid && s_axis_tready;
    assign cfg_ready      = 1'b1;

    always_comb
    begin
        rd_ctl.valid   = accept;
        rd_ctl.border  = (row_index_reg == '0) || (col_index_reg == '0);
        rd_ctl.col_end = col_end;
        rd_ctl.last    = s_axis_tlast;
    end

    lesq_score_core #(
        .MAX_ROWS (MAX_ROWS),
        .ROW_W    (ROW_W)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .obstacle_char (obstacle_reg),
        .rd_ctl        (rd_ctl),
        .rd_addr       (row_index_reg),
        .rd_char       (s_axis_tdata),
        .s1_ctl        (s1_ctl),
        .s2_ctl        (s2_ctl),
        .s2_score      (s2_score),
        .s2_addr       (s2_addr)
    );

    always_comb
    begin
        best_size_next = best_size_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (s2_score > best_size_reg)
        begin
            best_size_next = s2_score;
            best_row_next  = s2_addr;
            best_col_next  = col_s2_reg;
        end
        top_sum  = SUM_W'(best_row_next) + SUM_W'(1) - SUM_W'(best_size_next);
        left_sum = SUM_W'(best_col_next) + SUM_W'(1) - SUM_W'(best_size_next);
    end

    always_ff @(posedge clk)
    begin
        col_s1_reg <= col_index_reg;
        col_s2_reg <= col_s1_reg;
        if (s2_ctl.valid && s2_ctl.last)
        begin
            if (best_size_next == '0)
            begin
                top_row_reg  <= '0;
                left_col_reg <= '0;
            end
            else
            begin
                top_row_reg  <= top_sum[POS_W-1:0];
                left_col_reg <= left_sum[POS_W-1:0];
            end
            size_reg <= best_size_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_reg  <= OBSTACLE_RESET;
            row_count_reg <= ROW_COUNT_RESET;
            row_index_reg <= '0;
            col_index_reg <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_OBSTACLE_CHAR: obstacle_reg  <= cfg_data[CHAR_W-1:0];
                    CFG_ROW_COUNT:     row_count_reg <= cfg_data;
                    default:           ;
                endcase
            end

            // advance the scan position
            if (accept)
            begin
                if (s_axis_tlast)
                begin
                    row_index_reg <= '0;
                    col_index_reg <= '0;
                end
                else if (col_end)
                begin
                    row_index_reg <= '0;
                    if (col_index_reg == COL_W'(MAX_COLS - 1))
                    begin
                        col_index_reg <= '0;
                    end
                    else
                    begin
                        col_index_reg <= col_index_reg + COL_W'(1);
                    end
                end
                else
                begin
                    row_index_reg <= row_index_reg + ROW_W'(1);
                end
            end

            // track the best square, drop it after the last cell
            if (s2_ctl.valid)
            begin
                if (s2_ctl.last)
                begin
                    best_size_reg <= '0;
                    best_row_reg  <= '0;
                    best_col_reg  <= '0;
                end
                else
                begin
                    best_size_reg <= best_size_next;
                    best_row_reg  <= best_row_next;
                    best_col_reg  <= best_col_next;
                end
            end

            if (s2_ctl.valid && s2_ctl.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, size_reg, left_col_reg, top_row_reg};

endmodule

>>> tb/largest_empty_square_search_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for largest_empty_square_search: directed and random
// column-major maps against a cycle-free score predictor. Depends on lesq_pkg.
module largest_empty_square_search_tb;

    import lesq_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]   top_row;
        logic [POS_W-1:0]   left_col;
        logic [SCORE_W-1:0] square_size;
    } square_t;

    class square_board;
        logic [CHAR_W-1:0]   obstacle;
        logic [ROWCNT_W-1:0] rows_cfg;
        logic [SCORE_W-1:0]  col_scores [DEF_MAX_ROWS];
        logic [SCORE_W-1:0]  north;
        logic [SCORE_W-1:0]  north_west;
        logic [SCORE_W-1:0]  best_size;
        logic [POS_W-1:0]    row_idx;
        logic [POS_W-1:0]    col_idx;
        logic [POS_W-1:0]    best_row;
        logic [POS_W-1:0]    best_col;
        square_t             awaited [$];
        int                  errors;

        function new();
            obstacle = OBSTACLE_RESET;
            rows_cfg = ROW_COUNT_RESET;
            errors   = 0;
            foreach (col_scores[i])
                col_scores[i] = '0;
            restart();
        endfunction

        function void restart();
            north      = '0;
            north_west = '0;
            row_idx    = '0;
            col_idx    = '0;
            best_size  = '0;
            best_row   = '0;
            best_col   = '0;
        endfunction

        function int unsigned rows_active();
            if (rows_cfg == 0)
                return 1;
            if (rows_cfg > DEF_MAX_ROWS)
                return DEF_MAX_ROWS;
            return rows_cfg;
        endfunction

        function void set_reg(cfg_index_t idx, logic [ROWCNT_W-1:0] value);
            case (idx)
                CFG_OBSTACLE_CHAR: obstacle = value[CHAR_W-1:0];
                CFG_ROW_COUNT:     rows_cfg = value;
                default:           ;
            endcase
        endfunction

        function void note_cell(logic [CHAR_W-1:0] ch, logic last);
            int unsigned rows;
            int unsigned r;
            int unsigned west;
            int unsigned low;
            int unsigned score;
            square_t     sq;
            rows = rows_active();
            r    = row_idx % DEF_MAX_ROWS;
            west = col_scores[r];
            if (ch == obstacle)
                score = 0;
            else if (r == 0 || col_idx == 0)
                score = 1;
            else
            begin
                low = north;
                if (north_west < low)
                    low = north_west;
                if (west < low)
                    low = west;
                score = low + 1;
            end
            score = score & 32'h7FF;
            north_west    = SCORE_W'(west);
            north         = SCORE_W'(score);
            col_scores[r] = SCORE_W'(score);
            if (score > best_size)
            begin
                best_size = SCORE_W'(score);
                best_row  = POS_W'(r);
                best_col  = col_idx;
            end
            if (r + 1 >= rows)
            begin
                row_idx    = '0;
                north      = '0;
                north_west = '0;
                col_idx    = col_idx + 1'b1;
            end
            else
                row_idx = POS_W'(r + 1);
            if (!last)
                return;
            if (best_size == 0)
                sq = '0;
            else
            begin
                sq.top_row     = best_row + 1'b1 - best_size[POS_W-1:0];
                sq.left_col    = best_col + 1'b1 - best_size[POS_W-1:0];
                sq.square_size = best_size;
            end
            awaited.push_back(sq);
            restart();
        endfunction

        function void check_square(logic [OUT_DATA_W-1:0] word);
            square_t got;
            square_t want;
            got.top_row     = word[9:0];
            got.left_col    = word[19:10];
            got.square_size = word[30:20];
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result top_row %0d left_col %0d size %0d",
                         $time, got.top_row, got.left_col, got.square_size);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.top_row !== want.top_row)
            begin
                $display("%0t: top_row expected %0d actual %0d",
                         $time, want.top_row, got.top_row);
                errors++;
            end
            if (got.left_col !== want.left_col)
            begin
                $display("%0t: left_col expected %0d actual %0d",
                         $time, want.left_col, got.left_col);
                errors++;
            end
            if (got.square_size !== want.square_size)
            begin
                $display("%0t: square_size expected %0d actual %0d",
                         $time, want.square_size, got.square_size);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [ROWCNT_W-1:0]   cfg_data;

    square_board board;
    bit          burst;
    bit          rx_calm;

    largest_empty_square_search u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap(bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [CHAR_W-1:0] free_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == board.obstacle);
        return c;
    endfunction

    task automatic send_cell(input logic [CHAR_W-1:0] ch, input logic last);
        int gap;
        gap = pick_gap(burst);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_cell(ch, last);
    endtask

    task automatic send_pattern(input logic [63:0] empty_mask, input int count,
                                input bit close);
        for (int i = 0; i < count; i++)
            send_cell(empty_mask[i] ? free_char() : board.obstacle,
                      close && i == count - 1);
    endtask

    // Hold the sender until every result is back and the pipeline is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [ROWCNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int stall;
        stall         = 0;
        rx_calm       = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_square(m_axis_tdata);
            if ($urandom_range(0, 199) == 0)
                rx_calm = ~rx_calm;
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 3) == 0)
            begin
                stall = pick_gap(1'b0);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int                  random_cells;
        int                  cols;
        int                  total;
        int                  density;
        int                  roll;
        logic [ROWCNT_W-1:0] rows_val;
        board         = new();
        burst         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // partial column at the reset row count, only the final cell empty
        for (int i = 0; i < 40; i++)
            send_cell(i == 39 ? free_char() : board.obstacle, i == 39);
        settle();

        write_reg(CFG_OBSTACLE_CHAR, 11'd0);
        write_reg(CFG_ROW_COUNT, 11'd1);
        send_cell(8'h00, 1'b1);
        send_cell(8'hFF, 1'b1);
        settle();

        write_reg(CFG_OBSTACLE_CHAR, 11'd255);
        write_reg(CFG_ROW_COUNT, 11'd3);
        send_pattern(64'h1FF, 9, 1'b1);
        send_pattern(64'h1EF, 9, 1'b1);
        send_pattern(64'h1B0, 12, 1'b1);
        send_pattern(64'h0, 6, 1'b1);
        settle();

        // tie between two equal squares keeps the first
        write_reg(CFG_ROW_COUNT, 11'd2);
        send_pattern(64'h3CF, 10, 1'b1);
        settle();

        // shrink the row count in the middle of a map
        write_reg(CFG_OBSTACLE_CHAR, 11'd120);
        write_reg(CFG_ROW_COUNT, 11'd6);
        send_pattern(64'h3FF, 10, 1'b0);
        settle();
        write_reg(CFG_ROW_COUNT, 11'd3);
        send_pattern(64'hF, 4, 1'b1);
        settle();

        // row count above the store depth acts as the maximum
        write_reg(CFG_OBSTACLE_CHAR, 11'd170);
        write_reg(CFG_ROW_COUNT, 11'd2047);
        for (int i = 0; i < 30; i++)
            send_cell(i == 29 ? free_char() : board.obstacle, i == 29);
        settle();

        // zero rows acts as one
        write_reg(CFG_OBSTACLE_CHAR, 11'd85);
        write_reg(CFG_ROW_COUNT, 11'd0);
        for (int i = 0; i < 24; i++)
            send_cell(i == 23 ? free_char() : board.obstacle, i == 23);
        settle();

        random_cells = 0;
        while (random_cells < 400)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
            begin
                settle();
                write_reg(CFG_OBSTACLE_CHAR, ROWCNT_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 75)
                        rows_val = ROWCNT_W'($urandom_range(1, 8));
                    else if (roll < 90)
                        rows_val = ROWCNT_W'($urandom_range(9, 40));
                    else if (roll < 95)
                        rows_val = 11'd0;
                    else
                        rows_val = ROWCNT_W'($urandom_range(1025, 2047));
                    write_reg(CFG_ROW_COUNT, rows_val);
                end
            end
            else if (roll < 35)
                settle();
            burst = ($urandom_range(0, 4) == 0);
            cols  = $urandom_range(1, 8);
            total = board.rows_active() * cols;
            if (total > 64)
                total = $urandom_range(1, 64);
            else if ($urandom_range(0, 9) < 3)
                total = $urandom_range(1, total);
            case ($urandom_range(0, 4))
                0:       density = 0;
                1:       density = 10;
                2:       density = 25;
                3:       density = 60;
                default: density = 100;
            endcase
            for (int i = 0; i < total; i++)
                send_cell($urandom_range(0, 99) < density ? board.obstacle : free_char(),
                          i == total - 1);
            random_cells += total;
        end
        burst = 1'b0;

        settle();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
